// ----- rtl/tpts_pkg.sv -----
// Package for the three-level priority thread scheduler.
// Holds the shared codes, record types and reset constants.
// No dependencies.
package tpts_pkg;

  localparam int unsigned MaxThreads = 32;
  localparam int unsigned NumQueues  = 3;

  typedef enum logic [2:0] {
    OP_TICK      = 3'd0,
    OP_SPAWN     = 3'd1,
    OP_TERMINATE = 3'd2,
    OP_SUSPEND   = 3'd3,
    OP_RESUME    = 3'd4,
    OP_GET_QUANT = 3'd5,
    OP_GET_TOTAL = 3'd6,
    OP_BAD       = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_ERROR = 2'd1,
    ST_HALT  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    MODE_FREE      = 2'd0,
    MODE_READY     = 2'd1,
    MODE_RUNNING   = 2'd2,
    MODE_SUSPENDED = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_DISP,
    S_RUN,
    S_DONE
  } state_e;

  localparam logic [1:0] PrioRed    = 2'd0;
  localparam logic [1:0] PrioOrange = 2'd1;
  localparam logic [1:0] PrioGreen  = 2'd2;

  // One entry of the thread table
  typedef struct packed {
    mode_e       mode;
    logic [1:0]  prio;
    logic [31:0] quanta;
  } thread_rec_t;

  localparam thread_rec_t RecMainReset = '{mode: MODE_RUNNING, prio: PrioOrange, quanta: 32'd1};
  localparam thread_rec_t RecFree      = '{mode: MODE_FREE, prio: PrioRed, quanta: 32'd0};

  // Per-cycle command to one ready queue
  typedef struct packed {
    logic push;
    logic pop;
    logic rm;
    logic clear;
  } q_ctrl_t;

endpackage

// ----- rtl/three_level_priority_thread_scheduler.sv -----
// Three-level strict-priority round-robin thread scheduler, top level.
// Each command passes through execute, an optional dispatch read and run write,
// and the result load, and its result may then wait for the receiver.
// The input stalls until the result is loaded, so a new command is taken only after the last result.
// Reset (and terminating thread 0): thread 0 runs at orange priority, queues empty.
module three_level_priority_thread_scheduler #(
  parameter int unsigned MAX_THREADS = tpts_pkg::MaxThreads
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  operation_i,
  input  logic [4:0]  thread_id_i,
  input  logic [1:0]  priority_req_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [31:0] value_o,
  output logic [4:0]  running_id_o,
  output logic        running_valid_o
);
  import tpts_pkg::*;

  localparam int unsigned IW = $clog2(MAX_THREADS);
  localparam int unsigned CW = $clog2(MAX_THREADS + 1);

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    sat_inc = (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
  endfunction

  // Control and bookkeeping registers
  state_e         state_q, state_d;
  op_e            op_q;
  logic [4:0]     tid_q;
  logic [1:0]     pr_q;
  logic [IW-1:0]  cur_id_q, cur_id_d;
  logic           cur_vld_q, cur_vld_d;
  logic [31:0]    total_q, total_d;
  logic [CW-1:0]  live_q, live_d;
  logic [CW-1:0]  fresh_q, fresh_d;
  logic [IW-1:0]  rec_head_q, rec_head_d;
  logic [CW-1:0]  rec_cnt_q, rec_cnt_d;
  logic [IW-1:0]  h_q, h_d;
  logic           push_cur_q, push_cur_d;
  logic [1:0]     cur_prio_q, cur_prio_d;
  status_e        status_q, status_d;
  logic [31:0]    value_q, value_d;
  logic           out_vld_q;
  status_e        out_status_q;
  logic [31:0]    out_value_q;
  logic [4:0]     out_rid_q;
  logic           out_rvld_q;

  logic accept, out_free;
  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !(out_vld_q && out_stall_i);

  // Thread table memory with per-entry written bits
  thread_rec_t          tbl_mem_q [MAX_THREADS];
  logic [MAX_THREADS-1:0] tbl_vld_q;
  logic                 rd_en, wr_en, tbl_clr;
  logic [IW-1:0]        rd_addr, wr_addr;
  thread_rec_t          wr_word, rd_word_q, word;
  logic                 rd_vld_q, rd_zero_q;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      tbl_mem_q[wr_addr] <= wr_word;
    end
    if (rd_en) begin
      rd_word_q <= tbl_mem_q[rd_addr];
      rd_vld_q  <= tbl_vld_q[rd_addr];
      rd_zero_q <= (rd_addr == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tbl_vld_q <= '0;
    end else if (tbl_clr) begin
      tbl_vld_q <= '0;
    end else if (wr_en) begin
      tbl_vld_q[wr_addr] <= 1'b1;
    end
  end

  // Unwritten entries read as their reset contents
  assign word = rd_vld_q ? rd_word_q : (rd_zero_q ? RecMainReset : RecFree);

  // Recycled id FIFO memory
  logic [IW-1:0] rec_mem_q [MAX_THREADS];
  logic [IW-1:0] rec_rd_q;
  logic          rec_wr;
  logic [IW-1:0] rec_wr_id;
  logic [IW:0]   tail_sum;
  logic [IW-1:0] rec_tail;

  assign tail_sum = {1'b0, rec_head_q} + (IW+1)'(rec_cnt_q);
  assign rec_tail = (tail_sum >= (IW+1)'(MAX_THREADS))
                    ? IW'(tail_sum - (IW+1)'(MAX_THREADS)) : IW'(tail_sum);

  always_ff @(posedge clk_i) begin
    if (rec_wr) begin
      rec_mem_q[rec_tail] <= rec_wr_id;
    end
    if (accept) begin
      rec_rd_q <= rec_mem_q[rec_head_q];
    end
  end

  // Ready queues
  q_ctrl_t       qc [NumQueues];
  logic [IW-1:0] q_id;
  logic [NumQueues-1:0] q_ne;
  logic [IW-1:0] q_head [NumQueues];

  for (genvar k = 0; k < NumQueues; k++) begin : g_q
    tpts_queue #(.Depth(MAX_THREADS), .IdW(IW)) u_queue (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (qc[k]),
      .id_i       (q_id),
      .nonempty_o (q_ne[k]),
      .head_o     (q_head[k])
    );
  end

  // Highest non-empty queue
  logic          any_ready;
  logic [1:0]    pop_sel;
  logic [IW-1:0] pop_id;
  always_comb begin
    priority if (q_ne[0]) begin
      pop_sel = 2'd0;
    end else if (q_ne[1]) begin
      pop_sel = 2'd1;
    end else begin
      pop_sel = 2'd2;
    end
  end
  assign any_ready = |q_ne;
  assign pop_id    = q_head[pop_sel];

  // Target thread decode
  logic [31:0]   tid_ext, in_tid_ext;
  logic          tid_in_range, exists, tid_zero;
  logic [IW-1:0] tid_idx, in_tid_idx;
  logic [1:0]    spawn_prio;
  logic          spawn_full;
  logic [IW-1:0] spawn_id;

  assign tid_ext      = 32'(tid_q);
  assign in_tid_ext   = 32'(thread_id_i);
  assign tid_idx      = tid_ext[IW-1:0];
  assign in_tid_idx   = in_tid_ext[IW-1:0];
  assign tid_in_range = tid_ext < 32'(MAX_THREADS);
  assign tid_zero     = (tid_q == 5'd0);
  assign exists       = tid_in_range && (word.mode != MODE_FREE);
  assign spawn_prio   = (pr_q > PrioGreen) ? PrioGreen : pr_q;
  assign spawn_full   = (live_q >= CW'(MAX_THREADS))
                        || ((rec_cnt_q == '0) && (fresh_q >= CW'(MAX_THREADS)));
  assign spawn_id     = (rec_cnt_q != '0) ? rec_rd_q : fresh_q[IW-1:0];

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_EXEC;
      end
      S_EXEC: begin
        state_d = S_DONE;
        unique case (op_q)
          OP_TICK: begin
            if (!cur_vld_q) state_d = S_DISP;
            else if (any_ready) state_d = S_RUN;
          end
          OP_TERMINATE: begin
            if (!tid_zero && exists && word.mode == MODE_RUNNING) state_d = S_DISP;
          end
          OP_SUSPEND: begin
            if (!tid_zero && exists && word.mode == MODE_RUNNING) state_d = S_DISP;
          end
          OP_SPAWN, OP_RESUME, OP_GET_QUANT, OP_GET_TOTAL, OP_BAD: ;
          default: ;
        endcase
      end
      S_DISP: begin
        state_d = any_ready ? S_RUN : S_DONE;
      end
      S_RUN: begin
        state_d = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath actions for each state
  always_comb begin
    cur_id_d   = cur_id_q;
    cur_vld_d  = cur_vld_q;
    total_d    = total_q;
    live_d     = live_q;
    fresh_d    = fresh_q;
    rec_head_d = rec_head_q;
    rec_cnt_d  = rec_cnt_q;
    h_d        = h_q;
    push_cur_d = push_cur_q;
    cur_prio_d = cur_prio_q;
    status_d   = status_q;
    value_d    = value_q;
    rd_en      = 1'b0;
    rd_addr    = '0;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_word    = word;
    tbl_clr    = 1'b0;
    rec_wr     = 1'b0;
    rec_wr_id  = tid_idx;
    q_id       = tid_idx;
    for (int k = 0; k < NumQueues; k++) begin
      qc[k] = '0;
    end

    unique case (state_q)
      S_IDLE: begin
        // Read the target entry, or the running thread on tick
        rd_en    = accept;
        rd_addr  = (op_e'(operation_i) == OP_TICK) ? cur_id_q : in_tid_idx;
        status_d = ST_OK;
        value_d  = '0;
      end
      S_EXEC: begin
        unique case (op_q)
          OP_TICK: begin
            if (cur_vld_q && any_ready) begin
              // Pop the next thread, requeue the running one after it
              qc[pop_sel].pop = 1'b1;
              rd_en      = 1'b1;
              rd_addr    = pop_id;
              h_d        = pop_id;
              push_cur_d = 1'b1;
              cur_prio_d = (word.prio > PrioGreen) ? PrioGreen : word.prio;
              wr_en      = 1'b1;
              wr_addr    = cur_id_q;
              wr_word    = '{mode: MODE_READY, prio: word.prio, quanta: word.quanta};
            end else if (cur_vld_q) begin
              // Nothing else ready: count the running thread again
              wr_en   = 1'b1;
              wr_addr = cur_id_q;
              wr_word = '{mode: MODE_RUNNING, prio: word.prio,
                          quanta: sat_inc(word.quanta)};
              total_d = sat_inc(total_q);
            end
          end
          OP_SPAWN: begin
            if (spawn_full) begin
              status_d = ST_ERROR;
            end else begin
              if (rec_cnt_q != '0) begin
                rec_head_d = (rec_head_q == IW'(MAX_THREADS - 1)) ? '0 : rec_head_q + 1'b1;
                rec_cnt_d  = rec_cnt_q - 1'b1;
              end else begin
                fresh_d = fresh_q + 1'b1;
              end
              wr_en   = 1'b1;
              wr_addr = spawn_id;
              wr_word = '{mode: MODE_READY, prio: spawn_prio, quanta: 32'd0};
              q_id    = spawn_id;
              qc[spawn_prio].push = 1'b1;
              live_d  = live_q + 1'b1;
              value_d = 32'(spawn_id);
            end
          end
          OP_TERMINATE: begin
            if (tid_zero) begin
              // Halt: return everything to its reset values
              tbl_clr    = 1'b1;
              for (int k = 0; k < NumQueues; k++) begin
                qc[k].clear = 1'b1;
              end
              cur_id_d   = '0;
              cur_vld_d  = 1'b1;
              total_d    = 32'd1;
              live_d     = CW'(1);
              fresh_d    = CW'(1);
              rec_head_d = '0;
              rec_cnt_d  = '0;
              status_d   = ST_HALT;
            end else if (!exists) begin
              status_d = ST_ERROR;
            end else begin
              for (int k = 0; k < NumQueues; k++) begin
                qc[k].rm = (word.mode == MODE_READY);
              end
              wr_en   = 1'b1;
              wr_addr = tid_idx;
              wr_word = '{mode: MODE_FREE, prio: word.prio, quanta: 32'd0};
              if (rec_cnt_q < CW'(MAX_THREADS)) begin
                rec_wr    = 1'b1;
                rec_cnt_d = rec_cnt_q + 1'b1;
              end
              live_d = live_q - 1'b1;
            end
          end
          OP_SUSPEND: begin
            if (tid_zero || !exists) begin
              status_d = ST_ERROR;
            end else if (word.mode == MODE_RUNNING || word.mode == MODE_READY) begin
              for (int k = 0; k < NumQueues; k++) begin
                qc[k].rm = (word.mode == MODE_READY);
              end
              wr_en   = 1'b1;
              wr_addr = tid_idx;
              wr_word = '{mode: MODE_SUSPENDED, prio: word.prio, quanta: word.quanta};
            end
          end
          OP_RESUME: begin
            if (!exists) begin
              status_d = ST_ERROR;
            end else if (word.mode == MODE_SUSPENDED) begin
              wr_en   = 1'b1;
              wr_addr = tid_idx;
              wr_word = '{mode: MODE_READY, prio: word.prio, quanta: word.quanta};
              qc[(word.prio > PrioGreen) ? PrioGreen : word.prio].push = 1'b1;
            end
          end
          OP_GET_QUANT: begin
            if (!exists) status_d = ST_ERROR;
            else value_d = word.quanta;
          end
          OP_GET_TOTAL: begin
            value_d = total_q;
          end
          OP_BAD: begin
            status_d = ST_ERROR;
          end
          default: status_d = ST_ERROR;
        endcase
      end
      S_DISP: begin
        // Pick the head of the highest ready queue, or go idle
        if (any_ready) begin
          qc[pop_sel].pop = 1'b1;
          rd_en      = 1'b1;
          rd_addr    = pop_id;
          h_d        = pop_id;
          push_cur_d = 1'b0;
        end else begin
          cur_vld_d = 1'b0;
          cur_id_d  = '0;
        end
      end
      S_RUN: begin
        // Run the popped thread and count its quantum
        wr_en     = 1'b1;
        wr_addr   = h_q;
        wr_word   = '{mode: MODE_RUNNING, prio: word.prio, quanta: sat_inc(word.quanta)};
        total_d   = sat_inc(total_q);
        q_id      = cur_id_q;
        qc[cur_prio_q].push = push_cur_q;
        cur_id_d  = h_q;
        cur_vld_d = 1'b1;
      end
      S_DONE: ;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cur_id_q   <= '0;
      cur_vld_q  <= 1'b1;
      total_q    <= 32'd1;
      live_q     <= CW'(1);
      fresh_q    <= CW'(1);
      rec_head_q <= '0;
      rec_cnt_q  <= '0;
      push_cur_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      cur_id_q   <= cur_id_d;
      cur_vld_q  <= cur_vld_d;
      total_q    <= total_d;
      live_q     <= live_d;
      fresh_q    <= fresh_d;
      rec_head_q <= rec_head_d;
      rec_cnt_q  <= rec_cnt_d;
      push_cur_q <= push_cur_d;
      if (state_q == S_DONE && out_free) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  logic [31:0] cur_id_ext;
  assign cur_id_ext = 32'(cur_id_q);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= op_e'(operation_i);
      tid_q <= thread_id_i;
      pr_q  <= priority_req_i;
    end
    h_q        <= h_d;
    cur_prio_q <= cur_prio_d;
    status_q   <= status_d;
    value_q    <= value_d;
    if (state_q == S_DONE && out_free) begin
      out_status_q <= status_q;
      out_value_q  <= value_q;
      out_rid_q    <= cur_vld_q ? cur_id_ext[4:0] : 5'd0;
      out_rvld_q   <= cur_vld_q;
    end
  end

  assign in_stall_o      = (state_q != S_IDLE);
  assign out_valid_o     = out_vld_q;
  assign status_o        = out_status_q;
  assign value_o         = out_value_q;
  assign running_id_o    = out_rid_q;
  assign running_valid_o = out_rvld_q;

endmodule

// ----- rtl/tpts_cell.sv -----
// One slot of a ready queue: holds an id and shifts toward the head.
// Depends on tpts_pkg.
module tpts_cell #(
  parameter int unsigned IdW = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tpts_pkg::q_ctrl_t  ctrl_i,
  input  logic [IdW-1:0]     id_i,
  input  logic               shift_i,
  input  logic               prev_vld_i,
  input  logic               next_vld_i,
  input  logic [IdW-1:0]     next_id_i,
  output logic               shift_o,
  output logic               vld_o,
  output logic [IdW-1:0]     id_o
);
  import tpts_pkg::*;

  logic           vld_q, vld_d;
  logic [IdW-1:0] id_q, id_d;
  logic           match;

  // Remove request hitting this slot starts the shift here
  assign match   = ctrl_i.rm && vld_q && (id_q == id_i);
  assign shift_o = shift_i | match;

  // Clear, take the neighbor, or fill the first empty slot on push
  always_comb begin
    vld_d = vld_q;
    id_d  = id_q;
    if (ctrl_i.clear) begin
      vld_d = 1'b0;
    end else if (shift_o) begin
      vld_d = next_vld_i;
      id_d  = next_id_i;
    end else if (ctrl_i.push && !vld_q && prev_vld_i) begin
      vld_d = 1'b1;
      id_d  = id_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q <= id_d;
  end

  assign vld_o = vld_q;
  assign id_o  = id_q;

endmodule

// ----- rtl/tpts_queue.sv -----
// Ready queue built as a row of tpts_cell slots, head at slot zero.
// Depends on tpts_pkg and tpts_cell.
module tpts_queue #(
  parameter int unsigned Depth = 32,
  parameter int unsigned IdW   = 5
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  tpts_pkg::q_ctrl_t  ctrl_i,
  input  logic [IdW-1:0]     id_i,
  output logic               nonempty_o,
  output logic [IdW-1:0]     head_o
);
  import tpts_pkg::*;

  logic [Depth:0]   shift;
  logic [Depth-1:0] vld;
  logic [IdW-1:0]   ids [Depth];

  // Pop starts the shift at the head
  assign shift[0] = ctrl_i.pop;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic           prev_vld;
    logic           next_vld;
    logic [IdW-1:0] next_id;
    if (i == 0) begin : g_first
      assign prev_vld = 1'b1;
    end else begin : g_mid
      assign prev_vld = vld[i-1];
    end
    if (i == Depth - 1) begin : g_last
      assign next_vld = 1'b0;
      assign next_id  = '0;
    end else begin : g_inner
      assign next_vld = vld[i+1];
      assign next_id  = ids[i+1];
    end
    tpts_cell #(.IdW(IdW)) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl_i),
      .id_i       (id_i),
      .shift_i    (shift[i]),
      .prev_vld_i (prev_vld),
      .next_vld_i (next_vld),
      .next_id_i  (next_id),
      .shift_o    (shift[i+1]),
      .vld_o      (vld[i]),
      .id_o       (ids[i])
    );
  end

  assign nonempty_o = vld[0];
  assign head_o     = ids[0];

endmodule

// ----- test/tb_top.sv -----
// Testbench for the three-level priority thread scheduler.
// Drives scheduler commands, predicts each result and checks every transfer.
// Depends on tpts_pkg and three_level_priority_thread_scheduler.
module tb_top;
  import tpts_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NT = MaxThreads;
  localparam int unsigned CycleLimit = 400000;

  typedef struct packed {
    logic [2:0] op;
    logic [4:0] tid;
    logic [1:0] prio;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] value;
    logic [4:0]  run_id;
    logic        run_valid;
  } sched_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [2:0]  operation_i = '0;
  logic [4:0]  thread_id_i = '0;
  logic [1:0]  priority_req_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [1:0]  status_o;
  logic [31:0] value_o;
  logic [4:0]  running_id_o;
  logic        running_valid_o;

  three_level_priority_thread_scheduler dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow scheduler state
  mode_e       sh_mode [NT];
  logic [1:0]  sh_prio [NT];
  logic [31:0] sh_quanta [NT];
  int unsigned sh_ready [3][$];
  int unsigned sh_recycled [$];
  int unsigned sh_fresh, sh_live, sh_cur;
  bit          sh_cur_valid;
  logic [31:0] sh_total;

  cmd_t       pending_cmds [$];
  sched_res_t expected_results [$];
  int unsigned errors = 0;
  int unsigned cycles = 0;
  bit quiet_drv = 1'b0, quiet_mon = 1'b0;
  bit hold_drv = 1'b0;
  bit took = 1'b0;
  int unsigned hold_mon = 0;

  function automatic logic [31:0] sat_inc(logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  function automatic void shadow_reset();
    for (int i = 0; i < NT; i++) begin
      sh_mode[i] = MODE_FREE;
      sh_prio[i] = PrioRed;
      sh_quanta[i] = '0;
    end
    for (int q = 0; q < 3; q++) sh_ready[q].delete();
    sh_recycled.delete();
    sh_mode[0] = MODE_RUNNING;
    sh_prio[0] = PrioOrange;
    sh_quanta[0] = 32'd1;
    sh_fresh = 1;
    sh_live = 1;
    sh_cur = 0;
    sh_cur_valid = 1'b1;
    sh_total = 32'd1;
  endfunction

  function automatic void make_ready(int unsigned id);
    sh_ready[(sh_prio[id] > PrioGreen) ? 2 : sh_prio[id]].push_back(id);
    sh_mode[id] = MODE_READY;
  endfunction

  function automatic bit take_ready(output int unsigned id);
    for (int q = 0; q < 3; q++) begin
      if (sh_ready[q].size() != 0) begin
        id = sh_ready[q].pop_front();
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void drop_ready(int unsigned id);
    for (int q = 0; q < 3; q++)
      for (int i = 0; i < sh_ready[q].size(); i++)
        if (sh_ready[q][i] == id) begin
          sh_ready[q].delete(i);
          return;
        end
  endfunction

  function automatic void run(int unsigned id);
    sh_cur = id;
    sh_cur_valid = 1'b1;
    sh_mode[id] = MODE_RUNNING;
    sh_quanta[id] = sat_inc(sh_quanta[id]);
    sh_total = sat_inc(sh_total);
  endfunction

  function automatic void dispatch();
    int unsigned id;
    if (take_ready(id)) run(id);
    else begin
      sh_cur_valid = 1'b0;
      sh_cur = 0;
    end
  endfunction

  // Advance the shadow scheduler by one command and return its result
  function automatic sched_res_t schedule(cmd_t c);
    sched_res_t r;
    int unsigned id, tid;
    bit exists;
    mode_e was;
    tid = c.tid;
    exists = (tid < NT) && (sh_mode[tid] != MODE_FREE);
    r.status = ST_OK;
    r.value = '0;
    case (op_e'(c.op))
      OP_TICK: begin
        if (!sh_cur_valid) dispatch();
        else if (take_ready(id)) begin
          make_ready(sh_cur);
          run(id);
        end else run(sh_cur);
      end
      OP_SPAWN: begin
        if (sh_live >= NT) r.status = ST_ERROR;
        else begin
          if (sh_recycled.size() != 0) id = sh_recycled.pop_front();
          else if (sh_fresh < NT) id = sh_fresh++;
          else r.status = ST_ERROR;
          if (r.status == ST_OK) begin
            sh_prio[id] = (c.prio > PrioGreen) ? PrioGreen : c.prio;
            sh_quanta[id] = '0;
            make_ready(id);
            sh_live++;
            r.value = id;
          end
        end
      end
      OP_TERMINATE: begin
        if (tid == 0) begin
          shadow_reset();
          r.status = ST_HALT;
        end else if (!exists) r.status = ST_ERROR;
        else begin
          if (sh_mode[tid] == MODE_READY) drop_ready(tid);
          was = sh_mode[tid];
          sh_mode[tid] = MODE_FREE;
          sh_quanta[tid] = '0;
          if (sh_recycled.size() < NT) sh_recycled.push_back(tid);
          sh_live--;
          if (was == MODE_RUNNING) dispatch();
        end
      end
      OP_SUSPEND: begin
        if (tid == 0 || !exists) r.status = ST_ERROR;
        else if (sh_mode[tid] == MODE_RUNNING) begin
          sh_mode[tid] = MODE_SUSPENDED;
          dispatch();
        end else if (sh_mode[tid] == MODE_READY) begin
          drop_ready(tid);
          sh_mode[tid] = MODE_SUSPENDED;
        end
      end
      OP_RESUME: begin
        if (!exists) r.status = ST_ERROR;
        else if (sh_mode[tid] == MODE_SUSPENDED) make_ready(tid);
      end
      OP_GET_QUANT: begin
        if (!exists) r.status = ST_ERROR;
        else r.value = sh_quanta[tid];
      end
      OP_GET_TOTAL: r.value = sh_total;
      default: r.status = ST_ERROR;
    endcase
    r.run_id = sh_cur_valid ? sh_cur[4:0] : 5'd0;
    r.run_valid = sh_cur_valid;
    return r;
  endfunction

  // Random command, weighted toward ids 1 to 12
  function automatic cmd_t random_cmd();
    cmd_t c;
    int unsigned k;
    k = $urandom_range(99);
    if (k < 30) c.op = OP_TICK;
    else if (k < 52) c.op = OP_SPAWN;
    else if (k < 62) c.op = OP_TERMINATE;
    else if (k < 74) c.op = OP_SUSPEND;
    else if (k < 86) c.op = OP_RESUME;
    else if (k < 94) c.op = OP_GET_QUANT;
    else if (k < 98) c.op = OP_GET_TOTAL;
    else c.op = OP_BAD;
    c.tid = ($urandom_range(3) == 0) ? 5'($urandom) : 5'($urandom_range(1, 12));
    // Keep whole-scheduler resets rare
    if (c.op == OP_TERMINATE && c.tid == 0 && $urandom_range(7) != 0) c.tid = 5'd1;
    c.prio = 2'($urandom);
    return c;
  endfunction

  function automatic cmd_t mk(op_e op, int unsigned tid, int unsigned prio);
    cmd_t c;
    c.op = op;
    c.tid = tid[4:0];
    c.prio = prio[1:0];
    return c;
  endfunction

  // Driver: hold a waiting command, else present the next one or idle
  always @(negedge clk_i) begin
    bit waiting;
    if (rst_ni) begin
      waiting = in_valid_i && !took;
      took = 1'b0;
      if (waiting) begin
        in_valid_i <= 1'b1;
      end else if (hold_drv || pending_cmds.size() == 0 ||
                   (!quiet_drv && $urandom_range(99) < 16)) begin
        in_valid_i <= 1'b0;
      end else begin
        in_valid_i <= 1'b1;
        operation_i <= pending_cmds[0].op;
        thread_id_i <= pending_cmds[0].tid;
        priority_req_i <= pending_cmds[0].prio;
      end
    end
  end

  // Predict on accepted transfer and retire the command
  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o) begin
      expected_results.push_back(schedule(pending_cmds.pop_front()));
      took = 1'b1;
    end
  end

  // Monitor: compare each result transfer with the oldest prediction
  always @(posedge clk_i) begin
    sched_res_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_results.size() == 0) begin
        $error("result with no expectation pending");
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (status_o !== exp_r.status) begin
          $error("status: expected %0d actual %0d", exp_r.status, status_o);
          errors++;
        end
        if (value_o !== exp_r.value) begin
          $error("value: expected %0d actual %0d", exp_r.value, value_o);
          errors++;
        end
        if (running_id_o !== exp_r.run_id) begin
          $error("running_id: expected %0d actual %0d", exp_r.run_id, running_id_o);
          errors++;
        end
        if (running_valid_o !== exp_r.run_valid) begin
          $error("running_valid: expected %0d actual %0d", exp_r.run_valid,
                 running_valid_o);
          errors++;
        end
      end
    end
  end

  // Receiver stall: random, or a long hold-off when requested
  always @(negedge clk_i) begin
    if (hold_mon != 0) begin
      hold_mon <= hold_mon - 1;
      out_stall_i <= 1'b1;
    end else out_stall_i <= !quiet_mon && ($urandom_range(99) < 16);
  end

  // Cycle limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    shadow_reset();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: every operation, field extremes and the named corner cases
    pending_cmds.push_back(mk(OP_GET_TOTAL, 31, 3));
    pending_cmds.push_back(mk(OP_TICK, 0, 0));
    pending_cmds.push_back(mk(OP_SUSPEND, 0, 0));
    pending_cmds.push_back(mk(OP_GET_QUANT, 31, 0));
    pending_cmds.push_back(mk(OP_SPAWN, 0, 0));
    pending_cmds.push_back(mk(OP_SPAWN, 0, 1));
    pending_cmds.push_back(mk(OP_SPAWN, 0, 2));
    pending_cmds.push_back(mk(OP_SPAWN, 0, 3));
    pending_cmds.push_back(mk(OP_TICK, 0, 0));
    pending_cmds.push_back(mk(OP_TERMINATE, 2, 0));
    pending_cmds.push_back(mk(OP_SUSPEND, 3, 0));
    pending_cmds.push_back(mk(OP_SUSPEND, 3, 0));
    pending_cmds.push_back(mk(OP_TERMINATE, 1, 0));
    pending_cmds.push_back(mk(OP_RESUME, 3, 0));
    pending_cmds.push_back(mk(OP_RESUME, 0, 0));
    pending_cmds.push_back(mk(OP_SPAWN, 0, 1));
    pending_cmds.push_back(mk(OP_GET_QUANT, 0, 0));
    pending_cmds.push_back(mk(OP_BAD, 21, 3));
    pending_cmds.push_back(mk(OP_TERMINATE, 0, 0));
    for (int i = 0; i < 4; i++) pending_cmds.push_back(mk(OP_SUSPEND, 0, 0));
    // Fill to capacity, then overflow
    for (int i = 0; i < 33; i++) pending_cmds.push_back(mk(OP_SPAWN, 0, i % 4));
    for (int i = 1; i < 32; i++) pending_cmds.push_back(mk(OP_TERMINATE, i, 0));
    pending_cmds.push_back(mk(OP_TICK, 0, 0));

    // Random stretch with no idling, then a long receiver hold-off
    quiet_drv = 1'b1;
    quiet_mon = 1'b1;
    for (int i = 0; i < 200; i++) pending_cmds.push_back(random_cmd());
    wait (pending_cmds.size() < 150);
    quiet_drv = 1'b0;
    quiet_mon = 1'b0;
    @(negedge clk_i);
    hold_mon = 300;
    wait (pending_cmds.size() == 0);

    // Sender pause until every result has come
    hold_drv = 1'b1;
    wait (expected_results.size() == 0);
    repeat (10) @(posedge clk_i);
    hold_drv = 1'b0;

    for (int i = 0; i < 1350; i++) pending_cmds.push_back(random_cmd());
    wait (pending_cmds.size() == 0);
    wait (expected_results.size() == 0);
    repeat (20) @(posedge clk_i);

    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
